// ===== rtl/core/c8x_pkg.sv =====
// Shared types and constants for the CHIP-8 execute unit.
`timescale 1ns / 1ps
package c8x_pkg;

    // Storage sizes
    localparam int MEM_BYTES   = 4096;
    localparam int MEM_AW      = $clog2(MEM_BYTES);
    localparam int STACK_DEPTH = 16;
    localparam int STK_AW      = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int SCREEN_W    = 64;
    localparam int SCREEN_H    = 32;
    localparam int ROW_W       = $clog2(SCREEN_H);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [11:0] PC_RESET   = 12'd512;
    localparam logic [11:0] FONT_RESET = 12'h050;

    // Item functions
    localparam logic [1:0] FUNC_EXEC  = 2'd0;
    localparam logic [1:0] FUNC_MEMWR = 2'd1;
    localparam logic [1:0] FUNC_MEMRD = 2'd2;
    localparam logic [1:0] FUNC_ROWRD = 2'd3;

    // Fault codes
    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_OVER  = 2'd1;
    localparam logic [1:0] FAULT_UNDER = 2'd2;

    // Decoded operation class
    typedef enum logic [4:0] {
        K_MEMWR, K_MEMRD, K_ROWRD, K_NOP, K_CLS, K_RET, K_JP, K_CALL,
        K_SE_I, K_SNE_I, K_SE_R, K_SNE_R, K_LD_I, K_ADD_I, K_ALU, K_LDI,
        K_JPV0, K_RND, K_DRW, K_SKP, K_SKNP, K_LDDT, K_WAITK, K_STDT,
        K_STST, K_ADDI, K_FONT, K_BCD, K_STORE, K_LOAD
    } kind_t;

    // Back-end sequencer states
    typedef enum logic [3:0] {
        S_IDLE, S_RX, S_RY, S_EX, S_MRD, S_DRAW_ISSUE, S_DRAW_UPD,
        S_BCD, S_STORE, S_LOAD_ISSUE, S_LOAD_WR, S_FIN
    } state_t;

    // One classified word as it travels through the queue
    typedef struct packed {
        kind_t       kind;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [3:0]  n;
        logic [7:0]  nn;
        logic [11:0] nnn;
        logic [15:0] keys;
        logic [7:0]  rnd;
        logic [7:0]  dly;
        logic [11:0] addr;
        logic [7:0]  wdata;
        logic [4:0]  row;
    } item_t;

    // One result word
    typedef struct packed {
        logic [11:0] pc;
        logic [15:0] index;
        logic [7:0]  read_data;
        logic [63:0] display_row;
        logic        draw;
        logic        dly_v;
        logic [7:0]  dly_val;
        logic        snd_v;
        logic [7:0]  snd_val;
        logic [1:0]  fault;
    } res_t;

endpackage

// ===== rtl/core/chip8_instruction_executor.sv =====
// Top level of the CHIP-8 execute unit: front end, word queue, back end and font base register.
//
// Usage: one input word per in_valid/in_ready handshake; func selects opcode
// execution, a memory byte write, a memory byte read or a display row read.
// Every word returns exactly one result word on out_valid/out_ready, in order.
// The font base register is written through cfg_valid/cfg_ready/cfg_data,
// which is always ready; write it only while the unit is idle.
// Path: a word passes the front stage and the queue, then the back-end
// sequencer takes two register-read steps, one execute step and one result
// step, which loads the output register.
// The back-end sequencer works on one word at a time: memory reads, sprite
// draws, BCD, FX55 and FX65 add steps, and it takes the next word only once
// the output register is free or its result is being taken.
// The front stage and the two-entry queue keep accepting words while the
// back end works or while a result waits, until they are full.
// When the receiver stalls the result is held unchanged in the output
// register and the back end waits before starting the next word.
// Reset clears V0-VF, I, the stack pointer, the display and the key-wait
// flags, sets PC to 512 and the font base to 80; memory and stack contents
// stay undefined until written.
`timescale 1ns / 1ps
module chip8_instruction_executor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [15:0] opcode,
    input  logic [15:0] keys_down,
    input  logic [7:0]  random_byte,
    input  logic [7:0]  delay_value,
    input  logic [11:0] mem_address,
    input  logic [7:0]  write_data,
    input  logic [4:0]  row_select,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] pc_out,
    output logic [15:0] index_out,
    output logic [7:0]  read_data,
    output logic [63:0] display_row,
    output logic        draw,
    output logic        delay_write_valid,
    output logic [7:0]  delay_write_value,
    output logic        sound_write_valid,
    output logic [7:0]  sound_write_value,
    output logic [1:0]  fault,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [11:0] cfg_data
);

    logic           fe_valid;
    logic           fe_ready;
    c8x_pkg::item_t fe_item;
    logic           q_valid;
    logic           q_pop;
    c8x_pkg::item_t q_item;
    c8x_pkg::res_t  res;
    logic [11:0]    font_base_reg;
    logic [11:0]    font_base_next;

    // Font base configuration register
    assign cfg_ready      = 1'b1;
    assign font_base_next = (cfg_valid && cfg_ready) ? cfg_data : font_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            font_base_reg <= c8x_pkg::FONT_RESET;
        else
            font_base_reg <= font_base_next;
    end

    // Front end
    c8x_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .opcode      (opcode),
        .keys_down   (keys_down),
        .random_byte (random_byte),
        .delay_value (delay_value),
        .mem_address (mem_address),
        .write_data  (write_data),
        .row_select  (row_select),
        .ent_valid   (fe_valid),
        .ent_ready   (fe_ready),
        .ent         (fe_item)
    );

    // Word queue
    c8x_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fe_valid),
        .push_ready (fe_ready),
        .push_item  (fe_item),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_item   (q_item)
    );

    // Back end
    c8x_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .font_base (font_base_reg),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    // Result word fields
    assign pc_out            = res.pc;
    assign index_out         = res.index;
    assign read_data         = res.read_data;
    assign display_row       = res.display_row;
    assign draw              = res.draw;
    assign delay_write_valid = res.dly_v;
    assign delay_write_value = res.dly_val;
    assign sound_write_valid = res.snd_v;
    assign sound_write_value = res.snd_val;
    assign fault             = res.fault;

endmodule

// ===== rtl/core/c8x_front.sv =====
// Front end: registers incoming words and classifies the opcode.
`timescale 1ns / 1ps
module c8x_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        func,
    input  logic [15:0]       opcode,
    input  logic [15:0]       keys_down,
    input  logic [7:0]        random_byte,
    input  logic [7:0]        delay_value,
    input  logic [11:0]       mem_address,
    input  logic [7:0]        write_data,
    input  logic [4:0]        row_select,
    output logic              ent_valid,
    input  logic              ent_ready,
    output c8x_pkg::item_t    ent
);

    localparam logic [15:0] OP_CLS  = 16'h00E0;
    localparam logic [15:0] OP_RET  = 16'h00EE;
    localparam logic [7:0]  NN_SKP  = 8'h9E;
    localparam logic [7:0]  NN_SKNP = 8'hA1;
    localparam logic [7:0]  NN_LDDT = 8'h07;
    localparam logic [7:0]  NN_WAIT = 8'h0A;
    localparam logic [7:0]  NN_STDT = 8'h15;
    localparam logic [7:0]  NN_STST = 8'h18;
    localparam logic [7:0]  NN_ADDI = 8'h1E;
    localparam logic [7:0]  NN_FONT = 8'h29;
    localparam logic [7:0]  NN_BCD  = 8'h33;
    localparam logic [7:0]  NN_STOR = 8'h55;
    localparam logic [7:0]  NN_LOAD = 8'h65;

    logic           stage_valid_reg;
    logic           stage_valid_next;
    c8x_pkg::item_t stage_reg;
    c8x_pkg::item_t stage_next;
    c8x_pkg::kind_t kind;
    logic           accept;

    // Opcode classification
    always_comb
    begin
        kind = c8x_pkg::K_NOP;
        unique case (func)
            c8x_pkg::FUNC_MEMWR: kind = c8x_pkg::K_MEMWR;
            c8x_pkg::FUNC_MEMRD: kind = c8x_pkg::K_MEMRD;
            c8x_pkg::FUNC_ROWRD: kind = c8x_pkg::K_ROWRD;
            default:
            begin
                unique case (opcode[15:12])
                    4'h0:
                    begin
                        if (opcode == OP_CLS)
                            kind = c8x_pkg::K_CLS;
                        else if (opcode == OP_RET)
                            kind = c8x_pkg::K_RET;
                        else
                            kind = c8x_pkg::K_NOP;
                    end
                    4'h1: kind = c8x_pkg::K_JP;
                    4'h2: kind = c8x_pkg::K_CALL;
                    4'h3: kind = c8x_pkg::K_SE_I;
                    4'h4: kind = c8x_pkg::K_SNE_I;
                    4'h5: kind = c8x_pkg::K_SE_R;
                    4'h6: kind = c8x_pkg::K_LD_I;
                    4'h7: kind = c8x_pkg::K_ADD_I;
                    4'h8: kind = c8x_pkg::K_ALU;
                    4'h9: kind = c8x_pkg::K_SNE_R;
                    4'hA: kind = c8x_pkg::K_LDI;
                    4'hB: kind = c8x_pkg::K_JPV0;
                    4'hC: kind = c8x_pkg::K_RND;
                    4'hD: kind = c8x_pkg::K_DRW;
                    4'hE:
                    begin
                        if (opcode[7:0] == NN_SKP)
                            kind = c8x_pkg::K_SKP;
                        else if (opcode[7:0] == NN_SKNP)
                            kind = c8x_pkg::K_SKNP;
                        else
                            kind = c8x_pkg::K_NOP;
                    end
                    default:
                    begin
                        priority case (opcode[7:0])
                            NN_LDDT: kind = c8x_pkg::K_LDDT;
                            NN_WAIT: kind = c8x_pkg::K_WAITK;
                            NN_STDT: kind = c8x_pkg::K_STDT;
                            NN_STST: kind = c8x_pkg::K_STST;
                            NN_ADDI: kind = c8x_pkg::K_ADDI;
                            NN_FONT: kind = c8x_pkg::K_FONT;
                            NN_BCD:  kind = c8x_pkg::K_BCD;
                            NN_STOR: kind = c8x_pkg::K_STORE;
                            NN_LOAD: kind = c8x_pkg::K_LOAD;
                            default: kind = c8x_pkg::K_NOP;
                        endcase
                    end
                endcase
            end
        endcase
    end

    // Single holding stage in front of the queue
    assign in_ready = !stage_valid_reg || ent_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        stage_next       = stage_reg;
        stage_valid_next = stage_valid_reg && !ent_ready;
        if (accept)
        begin
            stage_valid_next  = 1'b1;
            stage_next.kind   = kind;
            stage_next.x      = opcode[11:8];
            stage_next.y      = opcode[7:4];
            stage_next.n      = opcode[3:0];
            stage_next.nn     = opcode[7:0];
            stage_next.nnn    = opcode[11:0];
            stage_next.keys   = keys_down;
            stage_next.rnd    = random_byte;
            stage_next.dly    = delay_value;
            stage_next.addr   = mem_address;
            stage_next.wdata  = write_data;
            stage_next.row    = row_select;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign ent_valid = stage_valid_reg;
    assign ent       = stage_reg;

endmodule

// ===== rtl/core/c8x_queue.sv =====
// Short queue of classified words between the front and back ends.
`timescale 1ns / 1ps
module c8x_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  c8x_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop,
    output c8x_pkg::item_t pop_item
);

    localparam int QAW = $clog2(c8x_pkg::QUEUE_DEPTH);
    localparam int CW  = $clog2(c8x_pkg::QUEUE_DEPTH + 1);

    c8x_pkg::item_t slots_reg [c8x_pkg::QUEUE_DEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW-1:0] rd_ptr_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           do_push;
    logic           do_pop;

    assign push_ready = (count_reg != CW'(c8x_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_item   = slots_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QAW'(c8x_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QAW'(c8x_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== rtl/core/c8x_back.sv =====
// Back end: sequencer that executes classified words against the machine state.
`timescale 1ns / 1ps
module c8x_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [11:0]    font_base,
    input  logic           q_valid,
    output logic           q_pop,
    input  c8x_pkg::item_t q_item,
    output logic           out_valid,
    input  logic           out_ready,
    output c8x_pkg::res_t  res
);

    localparam int          AW     = c8x_pkg::MEM_AW;
    localparam logic [3:0]  VF_IDX = 4'hF;
    localparam logic [3:0]  ALU_LD  = 4'h0;
    localparam logic [3:0]  ALU_OR  = 4'h1;
    localparam logic [3:0]  ALU_AND = 4'h2;
    localparam logic [3:0]  ALU_XOR = 4'h3;
    localparam logic [3:0]  ALU_ADD = 4'h4;
    localparam logic [3:0]  ALU_SUB = 4'h5;
    localparam logic [3:0]  ALU_SHR = 4'h6;
    localparam logic [3:0]  ALU_SBN = 4'h7;
    localparam logic [3:0]  ALU_SHL = 4'hE;

    c8x_pkg::state_t state_reg, state_next;
    c8x_pkg::item_t  ent_reg, ent_next;
    c8x_pkg::res_t   acc_reg, acc_next;
    c8x_pkg::res_t   out_reg, out_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      a_reg, a_next;
    logic [7:0]      b_reg, b_next;
    logic [3:0]      cnt_reg, cnt_next;
    logic            hit_reg, hit_next;
    logic [7:0]      vregs_reg [16];
    logic [7:0]      vregs_next [16];
    logic [63:0]     frame_reg [c8x_pkg::SCREEN_H];
    logic [63:0]     frame_next [c8x_pkg::SCREEN_H];
    logic [11:0]     pc_reg, pc_next;
    logic [15:0]     index_reg, index_next;
    logic [c8x_pkg::SP_W-1:0] sp_reg, sp_next;
    logic            kp_reg, kp_next;
    logic            kr_reg, kr_next;

    // Call stack and byte memory, no reset
    logic [11:0]     stack_mem [c8x_pkg::STACK_DEPTH];
    logic            stk_we;
    logic [c8x_pkg::STK_AW-1:0] stk_waddr;
    logic [11:0]     stk_wdata;
    logic [7:0]      mem [c8x_pkg::MEM_BYTES];
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [7:0]      mem_wdata;
    logic [AW-1:0]   mem_raddr;
    logic [7:0]      mem_rdata_reg;

    // Shared helpers
    logic [3:0]      vrd_addr;
    logic [7:0]      vrd;
    logic [11:0]     pcp2;
    logic [11:0]     pcp4;
    logic [AW-1:0]   iaddr;
    logic [5:0]      draw_row;
    logic [63:0]     sprite_bits;
    logic [7:0]      bcd_rem;
    logic [14:0]     bcd_prod;
    logic [3:0]      bcd_h;
    logic [3:0]      bcd_t;
    logic [3:0]      bcd_o;
    logic [3:0]      first_key;
    logic [8:0]      alu_sum;
    logic [c8x_pkg::SP_W-1:0] sp_m1;

    assign pcp2        = pc_reg + 12'd2;
    assign pcp4        = pc_reg + 12'd4;
    assign iaddr       = index_reg[AW-1:0] + AW'(cnt_reg);
    assign draw_row    = {1'b0, b_reg[4:0]} + {2'b00, cnt_reg};
    assign sprite_bits = {mem_rdata_reg, 56'd0} >> a_reg[5:0];
    assign vrd         = vregs_reg[vrd_addr];
    assign alu_sum     = {1'b0, a_reg} + {1'b0, b_reg};
    assign sp_m1       = sp_reg - 1'b1;

    // Decimal digits of Vx: hundreds by compare, tens by reciprocal multiply
    always_comb
    begin
        if (a_reg >= 8'd200)
        begin
            bcd_h   = 4'd2;
            bcd_rem = a_reg - 8'd200;
        end
        else if (a_reg >= 8'd100)
        begin
            bcd_h   = 4'd1;
            bcd_rem = a_reg - 8'd100;
        end
        else
        begin
            bcd_h   = 4'd0;
            bcd_rem = a_reg;
        end
        bcd_prod = 15'(bcd_rem) * 15'd205;
        bcd_t    = bcd_prod[14:11];
        bcd_o    = 4'(bcd_rem - 8'(bcd_t) * 8'd10);
    end

    // Lowest held key
    always_comb
    begin
        first_key = 4'd0;
        for (int k = 15; k >= 0; k--)
        begin
            if (ent_reg.keys[k])
                first_key = 4'(k);
        end
    end

    // Register file read address follows the sequencer step
    always_comb
    begin
        unique case (state_reg)
            c8x_pkg::S_RX:    vrd_addr = (ent_reg.kind == c8x_pkg::K_JPV0) ? 4'd0 : ent_reg.x;
            c8x_pkg::S_RY:    vrd_addr = ent_reg.y;
            c8x_pkg::S_STORE: vrd_addr = cnt_reg;
            default:          vrd_addr = ent_reg.x;
        endcase
    end

    // Sequencer: next state and datapath updates
    always_comb
    begin
        logic       w_kp;
        logic       w_kr;
        logic [7:0] w_v;

        state_next     = state_reg;
        ent_next       = ent_reg;
        acc_next       = acc_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        a_next         = a_reg;
        b_next         = b_reg;
        cnt_next       = cnt_reg;
        hit_next       = hit_reg;
        vregs_next     = vregs_reg;
        frame_next     = frame_reg;
        pc_next        = pc_reg;
        index_next     = index_reg;
        sp_next        = sp_reg;
        kp_next        = kp_reg;
        kr_next        = kr_reg;
        q_pop          = 1'b0;
        stk_we         = 1'b0;
        stk_waddr      = sp_reg[c8x_pkg::STK_AW-1:0];
        stk_wdata      = pcp2;
        mem_we         = 1'b0;
        mem_waddr      = iaddr;
        mem_wdata      = 8'd0;
        mem_raddr      = iaddr;
        w_kp           = kp_reg;
        w_kr           = kr_reg;
        w_v            = a_reg;

        unique case (state_reg)
            c8x_pkg::S_IDLE:
            begin
                if (q_valid && (!out_valid_reg || out_ready))
                begin
                    q_pop      = 1'b1;
                    ent_next   = q_item;
                    acc_next   = '0;
                    cnt_next   = 4'd0;
                    hit_next   = 1'b0;
                    state_next = c8x_pkg::S_RX;
                end
            end

            c8x_pkg::S_RX:
            begin
                a_next     = vrd;
                state_next = c8x_pkg::S_RY;
            end

            c8x_pkg::S_RY:
            begin
                b_next     = vrd;
                state_next = c8x_pkg::S_EX;
            end

            c8x_pkg::S_EX:
            begin
                state_next = c8x_pkg::S_FIN;
                if (ent_reg.kind != c8x_pkg::K_MEMWR && ent_reg.kind != c8x_pkg::K_MEMRD &&
                    ent_reg.kind != c8x_pkg::K_ROWRD)
                    pc_next = pcp2;
                unique case (ent_reg.kind)
                    c8x_pkg::K_MEMWR:
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(ent_reg.addr);
                        mem_wdata = ent_reg.wdata;
                    end
                    c8x_pkg::K_MEMRD:
                    begin
                        mem_raddr  = AW'(ent_reg.addr);
                        state_next = c8x_pkg::S_MRD;
                    end
                    c8x_pkg::K_ROWRD: acc_next.display_row = frame_reg[ent_reg.row];
                    c8x_pkg::K_CLS:
                    begin
                        for (int r = 0; r < c8x_pkg::SCREEN_H; r++)
                            frame_next[r] = '0;
                    end
                    c8x_pkg::K_RET:
                    begin
                        if (sp_reg == '0 || sp_reg > c8x_pkg::SP_W'(c8x_pkg::STACK_DEPTH))
                            acc_next.fault = c8x_pkg::FAULT_UNDER;
                        else
                        begin
                            sp_next = sp_m1;
                            pc_next = stack_mem[sp_m1[c8x_pkg::STK_AW-1:0]];
                        end
                    end
                    c8x_pkg::K_JP: pc_next = ent_reg.nnn;
                    c8x_pkg::K_CALL:
                    begin
                        if (sp_reg >= c8x_pkg::SP_W'(c8x_pkg::STACK_DEPTH))
                            acc_next.fault = c8x_pkg::FAULT_OVER;
                        else
                        begin
                            stk_we  = 1'b1;
                            sp_next = sp_reg + 1'b1;
                            pc_next = ent_reg.nnn;
                        end
                    end
                    c8x_pkg::K_SE_I:  if (a_reg == ent_reg.nn) pc_next = pcp4;
                    c8x_pkg::K_SNE_I: if (a_reg != ent_reg.nn) pc_next = pcp4;
                    c8x_pkg::K_SE_R:  if (a_reg == b_reg) pc_next = pcp4;
                    c8x_pkg::K_SNE_R: if (a_reg != b_reg) pc_next = pcp4;
                    c8x_pkg::K_LD_I:  vregs_next[ent_reg.x] = ent_reg.nn;
                    c8x_pkg::K_ADD_I: vregs_next[ent_reg.x] = a_reg + ent_reg.nn;
                    c8x_pkg::K_ALU:
                    begin
                        // Flag is written after the result so VF as target ends as the flag
                        unique case (ent_reg.n)
                            ALU_LD:  vregs_next[ent_reg.x] = b_reg;
                            ALU_OR:  vregs_next[ent_reg.x] = a_reg | b_reg;
                            ALU_AND: vregs_next[ent_reg.x] = a_reg & b_reg;
                            ALU_XOR: vregs_next[ent_reg.x] = a_reg ^ b_reg;
                            ALU_ADD:
                            begin
                                vregs_next[ent_reg.x] = alu_sum[7:0];
                                vregs_next[VF_IDX]    = {7'd0, alu_sum[8]};
                            end
                            ALU_SUB:
                            begin
                                vregs_next[ent_reg.x] = a_reg - b_reg;
                                vregs_next[VF_IDX]    = {7'd0, a_reg >= b_reg};
                            end
                            ALU_SHR:
                            begin
                                vregs_next[ent_reg.x] = {1'b0, a_reg[7:1]};
                                vregs_next[VF_IDX]    = {7'd0, a_reg[0]};
                            end
                            ALU_SBN:
                            begin
                                vregs_next[ent_reg.x] = b_reg - a_reg;
                                vregs_next[VF_IDX]    = {7'd0, b_reg >= a_reg};
                            end
                            ALU_SHL:
                            begin
                                vregs_next[ent_reg.x] = {a_reg[6:0], 1'b0};
                                vregs_next[VF_IDX]    = {7'd0, a_reg[7]};
                            end
                            default: ;
                        endcase
                    end
                    c8x_pkg::K_LDI:  index_next = {4'd0, ent_reg.nnn};
                    c8x_pkg::K_JPV0: pc_next = ent_reg.nnn + {4'd0, a_reg};
                    c8x_pkg::K_RND:  vregs_next[ent_reg.x] = ent_reg.rnd & ent_reg.nn;
                    c8x_pkg::K_DRW:
                    begin
                        acc_next.draw = 1'b1;
                        state_next    = c8x_pkg::S_DRAW_ISSUE;
                    end
                    c8x_pkg::K_SKP:
                        if (a_reg[7:4] == 4'd0 && ent_reg.keys[a_reg[3:0]]) pc_next = pcp4;
                    c8x_pkg::K_SKNP:
                        if (a_reg[7:4] == 4'd0 && !ent_reg.keys[a_reg[3:0]]) pc_next = pcp4;
                    c8x_pkg::K_LDDT: vregs_next[ent_reg.x] = ent_reg.dly;
                    c8x_pkg::K_WAITK:
                    begin
                        // Latch the lowest key, then wait for its release
                        if (!w_kp && ent_reg.keys != 16'd0)
                        begin
                            vregs_next[ent_reg.x] = {4'd0, first_key};
                            w_v  = {4'd0, first_key};
                            w_kp = 1'b1;
                        end
                        if (w_kp && !(w_v[7:4] == 4'd0 && ent_reg.keys[w_v[3:0]]))
                            w_kr = 1'b1;
                        if (!w_kp || !w_kr)
                        begin
                            pc_next = pc_reg;
                            kp_next = w_kp;
                            kr_next = w_kr;
                        end
                        else
                        begin
                            kp_next = 1'b0;
                            kr_next = 1'b0;
                        end
                    end
                    c8x_pkg::K_STDT:
                    begin
                        acc_next.dly_v   = 1'b1;
                        acc_next.dly_val = a_reg;
                    end
                    c8x_pkg::K_STST:
                    begin
                        acc_next.snd_v   = 1'b1;
                        acc_next.snd_val = a_reg;
                    end
                    c8x_pkg::K_ADDI: index_next = index_reg + {8'd0, a_reg};
                    c8x_pkg::K_FONT:
                        index_next = {4'd0, font_base} + {6'd0, a_reg, 2'b00} + {8'd0, a_reg};
                    c8x_pkg::K_BCD:   state_next = c8x_pkg::S_BCD;
                    c8x_pkg::K_STORE: state_next = c8x_pkg::S_STORE;
                    c8x_pkg::K_LOAD:  state_next = c8x_pkg::S_LOAD_ISSUE;
                    default: ;
                endcase
            end

            c8x_pkg::S_MRD:
            begin
                acc_next.read_data = mem_rdata_reg;
                state_next         = c8x_pkg::S_FIN;
            end

            // Sprite rows: fetch a byte, then XOR it into the frame
            c8x_pkg::S_DRAW_ISSUE:
            begin
                if (cnt_reg == ent_reg.n || draw_row[5])
                begin
                    vregs_next[VF_IDX] = {7'd0, hit_reg};
                    state_next         = c8x_pkg::S_FIN;
                end
                else
                    state_next = c8x_pkg::S_DRAW_UPD;
            end

            c8x_pkg::S_DRAW_UPD:
            begin
                if ((frame_reg[draw_row[4:0]] & sprite_bits) != 64'd0)
                    hit_next = 1'b1;
                frame_next[draw_row[4:0]] = frame_reg[draw_row[4:0]] ^ sprite_bits;
                cnt_next   = cnt_reg + 1'b1;
                state_next = c8x_pkg::S_DRAW_ISSUE;
            end

            c8x_pkg::S_BCD:
            begin
                mem_we = 1'b1;
                unique case (cnt_reg)
                    4'd0:    mem_wdata = {4'd0, bcd_h};
                    4'd1:    mem_wdata = {4'd0, bcd_t};
                    default: mem_wdata = {4'd0, bcd_o};
                endcase
                if (cnt_reg == 4'd2)
                    state_next = c8x_pkg::S_FIN;
                else
                    cnt_next = cnt_reg + 1'b1;
            end

            c8x_pkg::S_STORE:
            begin
                mem_we    = 1'b1;
                mem_wdata = vrd;
                if (cnt_reg == ent_reg.x)
                    state_next = c8x_pkg::S_FIN;
                else
                    cnt_next = cnt_reg + 1'b1;
            end

            c8x_pkg::S_LOAD_ISSUE:
                state_next = c8x_pkg::S_LOAD_WR;

            c8x_pkg::S_LOAD_WR:
            begin
                vregs_next[cnt_reg] = mem_rdata_reg;
                if (cnt_reg == ent_reg.x)
                    state_next = c8x_pkg::S_FIN;
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = c8x_pkg::S_LOAD_ISSUE;
                end
            end

            c8x_pkg::S_FIN:
            begin
                out_next       = acc_reg;
                out_next.pc    = pc_reg;
                out_next.index = index_reg;
                out_valid_next = 1'b1;
                state_next     = c8x_pkg::S_IDLE;
            end

            default: state_next = c8x_pkg::S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= c8x_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // Architectural state with defined reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pc_reg        <= c8x_pkg::PC_RESET;
            index_reg     <= '0;
            sp_reg        <= '0;
            kp_reg        <= 1'b0;
            kr_reg        <= 1'b0;
            cnt_reg       <= '0;
            hit_reg       <= 1'b0;
            for (int i = 0; i < 16; i++)
                vregs_reg[i] <= '0;
            for (int r = 0; r < c8x_pkg::SCREEN_H; r++)
                frame_reg[r] <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pc_reg        <= pc_next;
            index_reg     <= index_next;
            sp_reg        <= sp_next;
            kp_reg        <= kp_next;
            kr_reg        <= kr_next;
            cnt_reg       <= cnt_next;
            hit_reg       <= hit_next;
            vregs_reg     <= vregs_next;
            frame_reg     <= frame_next;
        end
    end

    // Working payload registers
    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
        acc_reg <= acc_next;
        out_reg <= out_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    // Byte memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_rdata_reg <= mem[mem_raddr];
    end

    // Return address stack
    always_ff @(posedge clk)
    begin
        if (stk_we)
            stack_mem[stk_waddr] <= stk_wdata;
    end

    assign out_valid = out_valid_reg;
    assign res       = out_reg;

`ifndef SYNTHESIS
    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= c8x_pkg::SP_W'(c8x_pkg::STACK_DEPTH))
        else $error("stack pointer beyond stack depth");
    a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg == c8x_pkg::S_RX)
        else $error("popped word did not start execution");
    a_fin_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == c8x_pkg::S_FIN |-> !out_valid_reg)
        else $error("result register still occupied at finish");
    a_fault_no_draw: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.fault != c8x_pkg::FAULT_NONE |-> !out_reg.draw)
        else $error("fault reported together with a draw");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the CHIP-8 execute unit, with a shadow model and scoreboard.
`timescale 1ns / 1ps
module tb_top;

    // One input word as the sender offers it.
    typedef struct {
        logic [1:0]  func;
        logic [15:0] op;
        logic [15:0] keys;
        logic [7:0]  rnd;
        logic [7:0]  dly;
        logic [11:0] addr;
        logic [7:0]  wd;
        logic [4:0]  row;
    } word_t;

    // Shadow copy of the unit's state, predicting one result word per input word.
    class exec_scoreboard;
        logic [7:0]  vreg [16];
        logic [15:0] idx;
        logic [11:0] pc;
        logic [11:0] stk [c8x_pkg::STACK_DEPTH];
        int          sp;
        logic [7:0]  mem [c8x_pkg::MEM_BYTES];
        bit          written [c8x_pkg::MEM_BYTES];
        logic [63:0] frame [c8x_pkg::SCREEN_H];
        bit          pressed_seen;
        bit          released_seen;
        logic [11:0] font_base;
        c8x_pkg::res_t pending_results [$];
        int          errors;

        function new();
            foreach (vreg[i]) vreg[i] = '0;
            foreach (frame[i]) frame[i] = '0;
            foreach (written[i]) written[i] = 0;
            idx = '0;
            pc = c8x_pkg::PC_RESET;
            sp = 0;
            pressed_seen = 0;
            released_seen = 0;
            font_base = c8x_pkg::FONT_RESET;
            errors = 0;
        endfunction

        function bit key_held(logic [15:0] keys, logic [7:0] k);
            return (k < 16) && keys[k[3:0]];
        endfunction

        function logic [11:0] wrap(int unsigned a);
            return 12'(a % c8x_pkg::MEM_BYTES);
        endfunction

        function void store(int unsigned a, logic [7:0] d);
            mem[wrap(a)] = d;
            written[wrap(a)] = 1;
        endfunction

        // Execute one opcode on the shadow state; fills in the side outputs.
        function void execute(word_t w, ref c8x_pkg::res_t r);
            logic [3:0]  x, y, n;
            logic [7:0]  nn, a, b, v;
            logic [11:0] nnn;
            logic [63:0] bits;
            bit          hit;
            int          sx, sy;
            x = w.op[11:8]; y = w.op[7:4]; n = w.op[3:0];
            nn = w.op[7:0]; nnn = w.op[11:0];
            a = vreg[x]; b = vreg[y];
            pc = pc + 12'd2;
            case (w.op[15:12])
                4'h0:
                    if (w.op == 16'h00E0) begin
                        foreach (frame[i]) frame[i] = '0;
                    end else if (w.op == 16'h00EE) begin
                        if (sp == 0)
                            r.fault = c8x_pkg::FAULT_UNDER;
                        else
                        begin
                            sp--;
                            pc = stk[sp];
                        end
                    end
                4'h1: pc = nnn;
                4'h2:
                    if (sp >= c8x_pkg::STACK_DEPTH)
                        r.fault = c8x_pkg::FAULT_OVER;
                    else
                    begin
                        stk[sp] = pc;
                        sp++;
                        pc = nnn;
                    end
                4'h3: if (a == nn) pc = pc + 12'd2;
                4'h4: if (a != nn) pc = pc + 12'd2;
                4'h5: if (a == b) pc = pc + 12'd2;
                4'h6: vreg[x] = nn;
                4'h7: vreg[x] = a + nn;
                4'h8:
                    case (n)
                        4'h0: vreg[x] = b;
                        4'h1: vreg[x] = a | b;
                        4'h2: vreg[x] = a & b;
                        4'h3: vreg[x] = a ^ b;
                        4'h4: begin vreg[x] = a + b; vreg[15] = 8'(9'(a) + b > 255); end
                        4'h5: begin vreg[x] = a - b; vreg[15] = 8'(a >= b); end
                        4'h6: begin vreg[x] = a >> 1; vreg[15] = {7'd0, a[0]}; end
                        4'h7: begin vreg[x] = b - a; vreg[15] = 8'(b >= a); end
                        4'hE: begin vreg[x] = a << 1; vreg[15] = {7'd0, a[7]}; end
                        default: ;
                    endcase
                4'h9: if (a != b) pc = pc + 12'd2;
                4'hA: idx = {4'h0, nnn};
                4'hB: pc = nnn + 12'(vreg[0]);
                4'hC: vreg[x] = w.rnd & nn;
                4'hD:
                begin
                    // Coordinates are taken before VF is cleared; rows past the bottom clip.
                    sx = a % c8x_pkg::SCREEN_W;
                    sy = b % c8x_pkg::SCREEN_H;
                    hit = 0;
                    for (int i = 0; i < n; i++)
                    begin
                        if (sy + i >= c8x_pkg::SCREEN_H) break;
                        bits = {mem[wrap(idx + i)], 56'b0} >> sx;
                        if ((frame[sy + i] & bits) != 0) hit = 1;
                        frame[sy + i] ^= bits;
                    end
                    vreg[15] = {7'd0, hit};
                    r.draw = 1'b1;
                end
                4'hE:
                    if (a < 16)
                    begin
                        if (nn == 8'h9E && key_held(w.keys, a)) pc = pc + 12'd2;
                        else if (nn == 8'hA1 && !key_held(w.keys, a)) pc = pc + 12'd2;
                    end
                default:
                    case (nn)
                        8'h07: vreg[x] = w.dly;
                        8'h0A:
                        begin
                            // Latch the lowest held key, then wait for it to go up.
                            if (!pressed_seen)
                                for (int k = 0; k < 16; k++)
                                    if (w.keys[k])
                                    begin
                                        vreg[x] = 8'(k);
                                        pressed_seen = 1;
                                        break;
                                    end
                            if (pressed_seen && !key_held(w.keys, vreg[x])) released_seen = 1;
                            if (!pressed_seen || !released_seen)
                                pc = pc - 12'd2;
                            else
                            begin
                                pressed_seen = 0;
                                released_seen = 0;
                            end
                        end
                        8'h15: begin r.dly_v = 1'b1; r.dly_val = a; end
                        8'h18: begin r.snd_v = 1'b1; r.snd_val = a; end
                        8'h1E: idx = idx + {8'd0, a};
                        8'h29: idx = 16'(font_base) + 16'(a) * 16'd5;
                        8'h33:
                        begin
                            store(idx, a / 100);
                            store(idx + 1, (a / 10) % 10);
                            store(idx + 2, a % 10);
                        end
                        8'h55: for (int i = 0; i <= x; i++) store(idx + i, vreg[i]);
                        8'h65: for (int i = 0; i <= x; i++) vreg[i] = mem[wrap(idx + i)];
                        default: ;
                    endcase
            endcase
        endfunction

        // Note an accepted input word and queue the result it must produce.
        function void note_word(word_t w);
            c8x_pkg::res_t r;
            r = '0;
            case (w.func)
                c8x_pkg::FUNC_EXEC:  execute(w, r);
                c8x_pkg::FUNC_MEMWR: store(w.addr, w.wd);
                c8x_pkg::FUNC_MEMRD: r.read_data = mem[wrap(w.addr)];
                default:             r.display_row = frame[w.row];
            endcase
            r.pc = pc;
            r.index = idx;
            pending_results.push_back(r);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
            errors++;
        endtask

        // Compare one accepted result word with the oldest expectation.
        task check_word(c8x_pkg::res_t got);
            c8x_pkg::res_t want;
            if (pending_results.size() == 0)
            begin
                report("unexpected result word", 64'(got.pc), 64'd0);
                return;
            end
            want = pending_results.pop_front();
            if (got.pc !== want.pc) report("pc_out", got.pc, want.pc);
            if (got.index !== want.index) report("index_out", got.index, want.index);
            if (got.read_data !== want.read_data)
                report("read_data", got.read_data, want.read_data);
            if (got.display_row !== want.display_row)
                report("display_row", got.display_row, want.display_row);
            if (got.draw !== want.draw) report("draw", got.draw, want.draw);
            if (got.dly_v !== want.dly_v) report("delay_write_valid", got.dly_v, want.dly_v);
            if (got.dly_val !== want.dly_val)
                report("delay_write_value", got.dly_val, want.dly_val);
            if (got.snd_v !== want.snd_v) report("sound_write_valid", got.snd_v, want.snd_v);
            if (got.snd_val !== want.snd_val)
                report("sound_write_value", got.snd_val, want.snd_val);
            if (got.fault !== want.fault) report("fault", got.fault, want.fault);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  func;
    logic [15:0] opcode;
    logic [15:0] keys_down;
    logic [7:0]  random_byte;
    logic [7:0]  delay_value;
    logic [11:0] mem_address;
    logic [7:0]  write_data;
    logic [4:0]  row_select;
    logic        out_valid;
    logic        out_ready;
    logic [11:0] pc_out;
    logic [15:0] index_out;
    logic [7:0]  read_data;
    logic [63:0] display_row;
    logic        draw;
    logic        delay_write_valid;
    logic [7:0]  delay_write_value;
    logic        sound_write_valid;
    logic [7:0]  sound_write_value;
    logic [1:0]  fault;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [11:0] cfg_data;

    exec_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off_req;
    int  words_sent;

    chip8_instruction_executor dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .func              (func),
        .opcode            (opcode),
        .keys_down         (keys_down),
        .random_byte       (random_byte),
        .delay_value       (delay_value),
        .mem_address       (mem_address),
        .write_data        (write_data),
        .row_select        (row_select),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .pc_out            (pc_out),
        .index_out         (index_out),
        .read_data         (read_data),
        .display_row       (display_row),
        .draw              (draw),
        .delay_write_valid (delay_write_valid),
        .delay_write_value (delay_write_value),
        .sound_write_valid (sound_write_valid),
        .sound_write_value (sound_write_value),
        .fault             (fault),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Receiver: random stalls, plus a long hold-off on request so the unit backs up.
    always @(posedge clk)
    begin
        static int hold_left = 0;
        if (!rst_n)
            out_ready <= 0;
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 0;
        end
        else if (hold_off_req)
        begin
            hold_off_req = 0;
            hold_left = 300;
            out_ready <= 0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result monitor.
    always @(posedge clk)
    begin
        c8x_pkg::res_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.pc = pc_out;
            got.index = index_out;
            got.read_data = read_data;
            got.display_row = display_row;
            got.draw = draw;
            got.dly_v = delay_write_valid;
            got.dly_val = delay_write_value;
            got.snd_v = sound_write_valid;
            got.snd_val = sound_write_value;
            got.fault = fault;
            sb.check_word(got);
        end
    end

    // Offer one word, with random idle cycles first, and wait for it to be taken.
    task send_word(input word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        func <= w.func;
        opcode <= w.op;
        keys_down <= w.keys;
        random_byte <= w.rnd;
        delay_value <= w.dly;
        mem_address <= w.addr;
        write_data <= w.wd;
        row_select <= w.row;
        do @(posedge clk); while (!in_ready);
        sb.note_word(w);
        words_sent++;
    endtask

    function word_t random_word(logic [1:0] f);
        word_t w;
        w.func = f;
        w.op = 16'($urandom_range(65535));
        w.keys = 16'($urandom_range(65535));
        w.rnd = 8'($urandom_range(255));
        w.dly = 8'($urandom_range(255));
        w.addr = 12'($urandom_range(4095));
        w.wd = 8'($urandom_range(255));
        w.row = 5'($urandom_range(31));
        return w;
    endfunction

    // Write a random byte at an address that has never been written.
    task fill_byte(input int unsigned a);
        word_t w;
        if (!sb.written[a % c8x_pkg::MEM_BYTES])
        begin
            w = random_word(c8x_pkg::FUNC_MEMWR);
            w.addr = 12'(a % c8x_pkg::MEM_BYTES);
            send_word(w);
        end
    endtask

    // Execute one opcode, first filling any memory bytes it would read.
    task run_op(input logic [15:0] op, input logic [15:0] keys);
        word_t w;
        int    sy;
        if (op[15:12] == 4'hD)
        begin
            sy = sb.vreg[op[7:4]] % c8x_pkg::SCREEN_H;
            for (int i = 0; i < op[3:0]; i++)
                if (sy + i < c8x_pkg::SCREEN_H) fill_byte(sb.idx + i);
        end
        if (op[15:12] == 4'hF && op[7:0] == 8'h65)
            for (int i = 0; i <= op[11:8]; i++) fill_byte(sb.idx + i);
        w = random_word(c8x_pkg::FUNC_EXEC);
        w.op = op;
        w.keys = keys;
        send_word(w);
    endtask

    task read_byte(input logic [11:0] a);
        word_t w;
        fill_byte(a);
        w = random_word(c8x_pkg::FUNC_MEMRD);
        w.addr = a;
        send_word(w);
    endtask

    // Pick a mostly well-formed opcode with random operands.
    function logic [15:0] pick_op();
        logic [15:0] op;
        logic [3:0]  g;
        op = 16'($urandom_range(65535));
        g = op[15:12];
        case (g)
            4'h0: op = ($urandom_range(2) == 0) ? 16'h00E0 :
                       ($urandom_range(1) == 0) ? 16'h00EE : op;
            4'h6: if ($urandom_range(1) == 0) op[7:0] = 8'($urandom_range(17));
            4'h8:
            begin
                static logic [3:0] alu_codes [10] = '{0, 1, 2, 3, 4, 5, 6, 7, 4'hE, 4'hC};
                op[3:0] = alu_codes[$urandom_range(9)];
            end
            4'hD: if ($urandom_range(3) != 0) op[3:0] = 4'($urandom_range(5));
            4'hE: op[7:0] = ($urandom_range(4) == 0) ? op[7:0] :
                            ($urandom_range(1) == 0) ? 8'h9E : 8'hA1;
            4'hF:
            begin
                static logic [7:0] f_codes [10] =
                    '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33, 8'h55, 8'h65, 8'h5A};
                op[7:0] = f_codes[$urandom_range(9)];
                if (op[7:0] == 8'h0A) op[7:0] = 8'h07;
            end
            default: ;
        endcase
        return op;
    endfunction

    // A key wait: nothing held, then a press, then the release.
    task key_wait_seq(input logic [3:0] x);
        logic [15:0] held;
        held = 16'($urandom_range(1, 65535));
        repeat ($urandom_range(2)) run_op({4'hF, x, 8'h0A}, 16'h0000);
        repeat ($urandom_range(1, 3)) run_op({4'hF, x, 8'h0A}, held);
        run_op({4'hF, x, 8'h0A}, ($urandom_range(3) == 0) ? ~held : 16'h0000);
        if (sb.pressed_seen) run_op({4'hF, x, 8'h0A}, 16'h0000);
    endtask

    task random_traffic(input int count);
        word_t w;
        int    sel;
        int    stop_at;
        stop_at = words_sent + count;
        while (words_sent < stop_at)
        begin
            sel = $urandom_range(99);
            if (sel < 8)
                read_byte(12'($urandom_range(4095)));
            else if (sel < 14)
                send_word(random_word(c8x_pkg::FUNC_MEMWR));
            else if (sel < 20)
                send_word(random_word(c8x_pkg::FUNC_ROWRD));
            else if (sel < 23)
                key_wait_seq(4'($urandom_range(15)));
            else if (sel < 25)
                repeat ($urandom_range(1, 18)) run_op({4'h2, 12'($urandom)}, 16'($urandom));
            else if (sel < 27)
                repeat ($urandom_range(1, 18)) run_op(16'h00EE, 16'($urandom));
            else if (sel < 32)
            begin
                // Noise: an arbitrary opcode word, key waits kept well-formed.
                w = random_word(c8x_pkg::FUNC_EXEC);
                if (w.op[15:12] == 4'hF && w.op[7:0] == 8'h0A) w.op[7:0] = 8'h1E;
                run_op(w.op, w.keys);
            end
            else
                run_op(pick_op(), 16'($urandom));
        end
    endtask

    // Stop offering words and let the unit drain before a register write.
    task drain();
        in_valid <= 0;
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task write_font_base(input logic [11:0] v);
        cfg_valid <= 1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
        sb.font_base = v;
    endtask

    // Main stimulus.
    initial
    begin
        logic [11:0] font_vals [4];
        static int   idle_vals [4] = '{0, 47, 0, 25};
        static int   stall_vals [4] = '{0, 0, 47, 25};
        sb = new();
        words_sent = 0;
        hold_off_req = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 0;
        in_valid = 0;
        func = c8x_pkg::FUNC_EXEC;
        opcode = '0;
        keys_down = '0;
        random_byte = '0;
        delay_value = '0;
        mem_address = '0;
        write_data = '0;
        row_select = '0;
        cfg_valid = 0;
        cfg_data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: field extremes and the corner cases of each group.
        run_op(16'h00EE, 16'h0000);        // return with empty stack
        run_op(16'h60FF, 16'hFFFF);
        run_op(16'h6F01, 16'h0000);
        run_op(16'h80F4, 16'h0000);        // add with carry
        run_op(16'h8F05, 16'h0000);        // subtract into VF
        run_op(16'h800E, 16'h0000);
        run_op(16'h8006, 16'h0000);
        run_op(16'hBFFF, 16'h0000);        // jump with V0 offset
        run_op(16'hA000, 16'h0000);
        run_op(16'hF033, 16'h0000);
        run_op(16'hD00F, 16'h0000);        // sprite at the top-left corner
        run_op(16'hD00F, 16'h0000);        // redraw clears: collision
        run_op(16'h0123, 16'h0000);        // other group 0 word does nothing
        run_op(16'h6110, 16'h0000);
        run_op(16'hE19E, 16'hFFFF);        // key index out of range
        run_op(16'hEFA1, 16'h0000);
        run_op(16'hF30A, 16'h0000);
        run_op(16'hF30A, 16'h0010);
        run_op(16'hF30A, 16'h0000);
        run_op(16'hAFFF, 16'h0000);
        run_op(16'hFF55, 16'h0000);        // store all registers across the top
        run_op(16'hFF65, 16'h0000);
        run_op(16'hF029, 16'h0000);
        run_op(16'h00E0, 16'h0000);

        // Random phases, one per idling pattern, each under a different font base.
        font_vals = '{12'h000, 12'hFFF, 12'($urandom), c8x_pkg::FONT_RESET};
        for (int p = 0; p < 4; p++)
        begin
            drain();
            write_font_base(font_vals[p]);
            send_idle_pct = idle_vals[p];
            recv_stall_pct = stall_vals[p];
            random_traffic(180);
            if (p == 1) hold_off_req = 1;
            random_traffic(190);
        end

        // Wait for the last results, then allow time for anything stray.
        drain();
        if (sb.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // Run-time limit.
    initial
    begin
        #40ms;
        $display("tb_top: errors");
        $finish;
    end

endmodule
